FILE: sv/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg
// Types and constants shared by the session sequence checker modules.
// ----------------------------------------------------------------------------
package ssc_pkg;

    localparam int unsigned CLIENT_W = 8;
    localparam int unsigned CONN_W   = 8;
    localparam int unsigned SEQ_W    = 32;
    localparam int unsigned STATUS_W = 3;

    // operation codes
    localparam logic OP_REQUEST  = 1'b0;
    localparam logic OP_RESPONSE = 1'b1;

    // counter value after reset
    localparam logic [SEQ_W-1:0] SEQ_RESET = SEQ_W'(1);

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED  = 3'd0,
        ST_WRONGCONN = 3'd1,
        ST_BADSEQ    = 3'd2,
        ST_RESPONSE  = 3'd3,
        ST_UNBOUND   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    // one session table entry
    typedef struct packed {
        logic              bound;
        logic [CONN_W-1:0] conn;
        logic [SEQ_W-1:0]  rx_expected;
        logic [SEQ_W-1:0]  tx_next;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic clear_en;
        logic in_ready;
        logic exec;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic accept;
        logic clear_last;
        logic out_busy;
    } t_dp_stat;

endpackage

FILE: sv/ssc_req_if.sv
// ----------------------------------------------------------------------------
// ssc_req_if
// Request channel: valid/ready handshake carrying one inbound item.
// ----------------------------------------------------------------------------
interface ssc_req_if
    import ssc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                operation;
    logic [CLIENT_W-1:0] client_id;
    logic [CONN_W-1:0]   connection_id;
    logic [SEQ_W-1:0]    seq_number;

    modport source (
        output valid, operation, client_id, connection_id, seq_number,
        input  ready
    );
    modport sink (
        input  valid, operation, client_id, connection_id, seq_number,
        output ready
    );
endinterface

FILE: sv/ssc_rsp_if.sv
// ----------------------------------------------------------------------------
// ssc_rsp_if
// Result channel: valid/ready handshake carrying one checked result.
// ----------------------------------------------------------------------------
interface ssc_rsp_if
    import ssc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [CLIENT_W-1:0] client_echo;
    logic [SEQ_W-1:0]    seq_out;
    logic [CONN_W-1:0]   bound_connection_out;

    modport source (
        output valid, status, client_echo, seq_out, bound_connection_out,
        input  ready
    );
    modport sink (
        input  valid, status, client_echo, seq_out, bound_connection_out,
        output ready
    );
endinterface

FILE: sv/ssc_ctrl.sv
// ----------------------------------------------------------------------------
// ssc_ctrl
// Controller: clearing pass after reset, then one request at a time.
// ----------------------------------------------------------------------------
module ssc_ctrl
    import ssc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_stat.accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_stat.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_en = 1'b1;
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
            end
            S_EXEC: begin
                o_cmd.exec = !i_stat.out_busy;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

FILE: sv/ssc_dp.sv
// ----------------------------------------------------------------------------
// ssc_dp
// Datapath: session table memory, request registers, check logic and the
// result register.
// ----------------------------------------------------------------------------
module ssc_dp
    import ssc_pkg::*;
#(
    parameter int unsigned CLIENTS = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_dp_cmd      i_cmd,
    output t_dp_stat     o_stat,
    ssc_req_if.sink      i_req,
    ssc_rsp_if.source    o_rsp
);

    localparam int unsigned IDX_W    = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int unsigned ID_SPAN  = 1 << CLIENT_W;

    // client id to table slot, worked out at elaboration
    logic [IDX_W-1:0] w_slot_tab [ID_SPAN];

    for (genvar g = 0; g < ID_SPAN; g++) begin : g_slot
        localparam int unsigned SLOT_V = g % CLIENTS;
        assign w_slot_tab[g] = IDX_W'(SLOT_V);
    end

    t_entry r_mem [CLIENTS];
    t_entry r_rd;

    logic [IDX_W-1:0]    r_clr_cnt;
    logic [IDX_W-1:0]    r_slot;
    logic                r_op;
    logic [CLIENT_W-1:0] r_cid;
    logic [CONN_W-1:0]   r_conn;
    logic [SEQ_W-1:0]    r_seq;

    logic                r_out_valid;
    t_status             r_status;
    logic [CLIENT_W-1:0] r_echo;
    logic [SEQ_W-1:0]    r_seq_out;
    logic [CONN_W-1:0]   r_conn_out;

    logic                w_accept;
    logic [IDX_W-1:0]    w_rd_slot;
    logic                w_we;
    logic [IDX_W-1:0]    w_wr_addr;
    t_entry              w_wr_data;
    t_entry              w_new;
    t_status             w_status;
    logic [SEQ_W-1:0]    w_seq_o;
    logic [CONN_W-1:0]   w_conn_o;
    logic [CONN_W-1:0]   w_conn_b;

    assign w_accept  = i_req.valid && i_cmd.in_ready;
    assign w_rd_slot = w_slot_tab[i_req.client_id];
    assign i_req.ready = i_cmd.in_ready;

    // status to the controller
    assign o_stat.accept     = w_accept;
    assign o_stat.clear_last = i_cmd.clear_en && (r_clr_cnt == IDX_W'(CLIENTS - 1));
    assign o_stat.out_busy   = r_out_valid && !o_rsp.ready;

    // clearing pass address counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clear_en) begin
            r_clr_cnt <= r_clr_cnt + IDX_W'(1);
        end
    end

    // request registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_slot <= w_rd_slot;
            r_op   <= i_req.operation;
            r_cid  <= i_req.client_id;
            r_conn <= i_req.connection_id;
            r_seq  <= i_req.seq_number;
        end
    end

    // check and update of the entry read for this request
    always_comb begin
        w_new    = r_rd;
        w_seq_o  = '0;
        w_conn_o = '0;
        w_conn_b = r_rd.bound ? r_rd.conn : r_conn;
        if (r_op == OP_REQUEST) begin
            w_new.bound = 1'b1;
            w_new.conn  = w_conn_b;
            w_seq_o     = r_rd.rx_expected;
            w_conn_o    = w_conn_b;
            if (w_conn_b != r_conn) begin
                w_status = ST_WRONGCONN;
            end else if (r_seq != r_rd.rx_expected) begin
                w_status = ST_BADSEQ;
            end else begin
                w_status          = ST_ACCEPTED;
                w_new.rx_expected = r_rd.rx_expected + SEQ_W'(1);
            end
        end else if (!r_rd.bound) begin
            w_status = ST_UNBOUND;
        end else begin
            w_status      = ST_RESPONSE;
            w_seq_o       = r_rd.tx_next;
            w_conn_o      = r_rd.conn;
            w_new.tx_next = r_rd.tx_next + SEQ_W'(1);
        end
    end

    // write port: clearing pass or write-back
    always_comb begin
        w_we      = i_cmd.clear_en || i_cmd.exec;
        w_wr_addr = i_cmd.clear_en ? r_clr_cnt : r_slot;
        if (i_cmd.clear_en) begin
            w_wr_data             = '0;
            w_wr_data.rx_expected = SEQ_RESET;
            w_wr_data.tx_next     = SEQ_RESET;
        end else begin
            w_wr_data = w_new;
        end
    end

    // session table memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_accept) begin
            r_rd <= r_mem[w_rd_slot];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status   <= w_status;
            r_echo     <= r_cid;
            r_seq_out  <= w_seq_o;
            r_conn_out <= w_conn_o;
        end
    end

    assign o_rsp.valid                = r_out_valid;
    assign o_rsp.status               = r_status;
    assign o_rsp.client_echo          = r_echo;
    assign o_rsp.seq_out              = r_seq_out;
    assign o_rsp.bound_connection_out = r_conn_out;

endmodule

FILE: sv/session_sequence_checker.sv
// Flow: a request is taken into the request registers and its table entry is read,
//   then the check result and the entry write-back are registered together.
// One request at a time, set by the table read-modify-write; a result stalled on
//   the output holds the write-back until it is taken.
// Reset: synchronous, active low; a clearing pass then writes every table entry,
//   and no request is taken until it ends.
// ----------------------------------------------------------------------------
// session_sequence_checker
// Per-client sequence number check over a session table in memory.
// ----------------------------------------------------------------------------
module session_sequence_checker
    import ssc_pkg::*;
#(
    parameter int unsigned CLIENTS = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ssc_req_if.sink    i_req,
    ssc_rsp_if.source  o_rsp
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // controller
    ssc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // datapath
    ssc_dp #(
        .CLIENTS (CLIENTS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

FILE: sv/ssc_checker.sv
// ----------------------------------------------------------------------------
// ssc_checker
// Port-level checks on the session sequence checker, bound to the top level.
// ----------------------------------------------------------------------------
module ssc_checker
    import ssc_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_req_valid,
    input logic                i_req_ready,
    input logic                i_rsp_valid,
    input logic                i_rsp_ready,
    input logic [STATUS_W-1:0] i_status,
    input logic [CLIENT_W-1:0] i_echo,
    input logic [SEQ_W-1:0]    i_seq_out,
    input logic [CONN_W-1:0]   i_conn_out
);

    // request ready is low during reset and as the clearing pass starts
    a_clear_after_reset: assert property (
        @(posedge i_clk) !i_rst_n |=> !i_req_ready
    ) else $error("request channel ready during clearing pass");

    // one request at a time
    a_one_in_flight: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready
    ) else $error("request taken while another is in flight");

    // an unbound response carries zero number and connection
    a_unbound_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_status == ST_UNBOUND) |->
            (i_seq_out == '0) && (i_conn_out == '0)
    ) else $error("unbound client result carries nonzero fields");

    // a stalled result holds
    a_rsp_hold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_status) && $stable(i_echo) &&
            $stable(i_seq_out) && $stable(i_conn_out)
    ) else $error("stalled result changed");

endmodule

bind session_sequence_checker ssc_checker u_ssc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_echo      (o_rsp.client_echo),
    .i_seq_out   (o_rsp.seq_out),
    .i_conn_out  (o_rsp.bound_connection_out)
);

FILE: tb/sv/session_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// session_table_checker
// Watches the request and result channels of the session sequence checker,
// keeps its own copy of the per-client session table, works out the verdict
// for every accepted request and compares each accepted result with the
// oldest verdict still due, field by field.
// ----------------------------------------------------------------------------
module session_table_checker
    import ssc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    ssc_req_if   i_req,
    ssc_rsp_if   i_rsp,
    output int   o_mismatches,
    output int   o_verdicts_due
);

    // one verdict the block owes
    typedef struct {
        t_status             status;
        logic [CLIENT_W-1:0] client;
        logic [SEQ_W-1:0]    seq;
        logic [CONN_W-1:0]   conn;
    } t_verdict;

    localparam int unsigned TABLE_DEPTH = 256;

    // shadow session table
    logic              shadow_bound [TABLE_DEPTH];
    logic [CONN_W-1:0] shadow_conn  [TABLE_DEPTH];
    logic [SEQ_W-1:0]  shadow_rx    [TABLE_DEPTH];
    logic [SEQ_W-1:0]  shadow_tx    [TABLE_DEPTH];

    t_verdict due_verdicts[$];
    int       mismatch_count;

    // apply one request to the shadow table and return the verdict it earns
    function automatic t_verdict apply_session_rules(
        input logic                op,
        input logic [CLIENT_W-1:0] cid,
        input logic [CONN_W-1:0]   conn,
        input logic [SEQ_W-1:0]    seq
    );
        t_verdict v;
        v.client = cid;
        v.seq    = '0;
        v.conn   = '0;
        if (op == OP_REQUEST) begin
            // first request binds the client to its connection
            if (!shadow_bound[cid]) begin
                shadow_bound[cid] = 1'b1;
                shadow_conn[cid]  = conn;
            end
            v.seq  = shadow_rx[cid];
            v.conn = shadow_conn[cid];
            if (shadow_conn[cid] != conn) begin
                v.status = ST_WRONGCONN;
            end else if (seq != shadow_rx[cid]) begin
                v.status = ST_BADSEQ;
            end else begin
                v.status       = ST_ACCEPTED;
                shadow_rx[cid] = shadow_rx[cid] + SEQ_W'(1);
            end
        end else if (!shadow_bound[cid]) begin
            // response for a client nobody has bound yet
            v.status = ST_UNBOUND;
        end else begin
            v.status       = ST_RESPONSE;
            v.seq          = shadow_tx[cid];
            v.conn         = shadow_conn[cid];
            shadow_tx[cid] = shadow_tx[cid] + SEQ_W'(1);
        end
        return v;
    endfunction

    // compare results, then take in new requests
    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            for (int k = 0; k < TABLE_DEPTH; k++) begin
                shadow_bound[k] = 1'b0;
                shadow_conn[k]  = '0;
                shadow_rx[k]    = SEQ_RESET;
                shadow_tx[k]    = SEQ_RESET;
            end
            due_verdicts.delete();
            mismatch_count = 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (due_verdicts.size() == 0) begin
                    $display("%0t unexpected result: status %0d client %0d seq %0d conn %0d",
                             $time, i_rsp.status, i_rsp.client_echo, i_rsp.seq_out,
                             i_rsp.bound_connection_out);
                    mismatch_count++;
                end else begin
                    want = due_verdicts.pop_front();
                    if (i_rsp.status !== want.status) begin
                        $display("%0t status mismatch: expected %0d actual %0d",
                                 $time, want.status, i_rsp.status);
                        mismatch_count++;
                    end
                    if (i_rsp.client_echo !== want.client) begin
                        $display("%0t client_echo mismatch: expected %0d actual %0d",
                                 $time, want.client, i_rsp.client_echo);
                        mismatch_count++;
                    end
                    if (i_rsp.seq_out !== want.seq) begin
                        $display("%0t seq_out mismatch: expected %h actual %h",
                                 $time, want.seq, i_rsp.seq_out);
                        mismatch_count++;
                    end
                    if (i_rsp.bound_connection_out !== want.conn) begin
                        $display("%0t bound_connection_out mismatch: expected %0d actual %0d",
                                 $time, want.conn, i_rsp.bound_connection_out);
                        mismatch_count++;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                due_verdicts.push_back(apply_session_rules(i_req.operation, i_req.client_id,
                                                           i_req.connection_id,
                                                           i_req.seq_number));
            end
        end
        o_mismatches   <= mismatch_count;
        o_verdicts_due <= due_verdicts.size();
    end

endmodule

FILE: tb/sv/session_sequence_checker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// session_sequence_checker_tb
// Drives requests and responses into the session sequence checker: a short
// directed run over binding, wrong connection, bad sequence and unbound
// responses, then mostly well-formed client traffic mixed with broken
// requests, with random gaps on the request side and random stalls on the
// result side. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module session_sequence_checker_tb;
    import ssc_pkg::*;

    localparam int RANDOM_ITEMS = 850;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_IDLE     = 11;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // request side drive
    logic                req_valid = 1'b0;
    logic                req_op    = OP_REQUEST;
    logic [CLIENT_W-1:0] req_cid   = '0;
    logic [CONN_W-1:0]   req_conn  = '0;
    logic [SEQ_W-1:0]    req_seq   = '0;
    logic                rsp_ready = 1'b0;
    logic                quiet     = 1'b0;
    int unsigned         rsp_hold  = 0;
    int unsigned         stall_left = 0;
    int                  cycle_count = 0;

    int mismatches;
    int verdicts_due;

    // session state as seen by the well-behaved clients
    logic              client_bound [256];
    logic [CONN_W-1:0] client_conn  [256];
    logic [SEQ_W-1:0]  client_next  [256];

    ssc_req_if req_ch ();
    ssc_rsp_if rsp_ch ();

    assign req_ch.valid         = req_valid;
    assign req_ch.operation     = req_op;
    assign req_ch.client_id     = req_cid;
    assign req_ch.connection_id = req_conn;
    assign req_ch.seq_number    = req_seq;
    assign rsp_ch.ready         = rsp_ready;

    session_sequence_checker #(
        .CLIENTS (256)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    session_table_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (req_ch),
        .i_rsp          (rsp_ch),
        .o_mismatches   (mismatches),
        .o_verdicts_due (verdicts_due)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side stalls, drawn once per result taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ready  <= 1'b0;
            stall_left <= 0;
        end else if (rsp_ready) begin
            if (rsp_ch.valid) begin
                rsp_hold = quiet ? 0 : $urandom_range(0, MAX_IDLE);
                if (rsp_hold != 0) begin
                    rsp_ready  <= 1'b0;
                    stall_left <= rsp_hold - 1;
                end
            end
        end else if (stall_left == 0) begin
            rsp_ready <= 1'b1;
        end else begin
            stall_left <= stall_left - 1;
        end
    end

    // send one request after a random gap and track what it does to the client
    task automatic send_item(
        input logic                op,
        input logic [CLIENT_W-1:0] cid,
        input logic [CONN_W-1:0]   conn,
        input logic [SEQ_W-1:0]    seq
    );
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_op    <= op;
        req_cid   <= cid;
        req_conn  <= conn;
        req_seq   <= seq;
        req_valid <= 1'b1;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        if (op == OP_REQUEST) begin
            if (!client_bound[cid]) begin
                client_bound[cid] = 1'b1;
                client_conn[cid]  = conn;
            end
            if (client_conn[cid] == conn && client_next[cid] == seq)
                client_next[cid] = client_next[cid] + SEQ_W'(1);
        end
    endtask

    // stop sending and hold off until every outstanding result has come back
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge i_clk);
        while (verdicts_due != 0) @(posedge i_clk);
    endtask

    // mostly a small working set of clients, sometimes any client
    function automatic logic [CLIENT_W-1:0] pick_client();
        if ($urandom_range(0, 3) == 0)
            return CLIENT_W'($urandom_range(0, 255));
        return CLIENT_W'($urandom_range(0, 15));
    endfunction

    initial begin
        logic [CLIENT_W-1:0] cid;
        logic [CONN_W-1:0]   conn;
        int unsigned         pick;

        for (int k = 0; k < 256; k++) begin
            client_bound[k] = 1'b0;
            client_conn[k]  = '0;
            client_next[k]  = SEQ_RESET;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: unbound responses, binding, rejects and extremes
        send_item(OP_RESPONSE, 8'd0,   8'hFF, 32'hFFFF_FFFF);
        send_item(OP_RESPONSE, 8'd255, 8'h00, 32'h0000_0000);
        send_item(OP_REQUEST,  8'd0,   8'd0,  32'd1);
        send_item(OP_REQUEST,  8'd0,   8'd0,  32'd1);
        send_item(OP_REQUEST,  8'd0,   8'd5,  32'd2);
        send_item(OP_REQUEST,  8'd0,   8'd0,  32'd2);
        send_item(OP_RESPONSE, 8'd0,   8'h3C, 32'hA5A5_A5A5);
        send_item(OP_RESPONSE, 8'd0,   8'h00, 32'h0000_0000);
        send_item(OP_REQUEST,  8'd255, 8'hFF, 32'hFFFF_FFFF);
        send_item(OP_REQUEST,  8'd255, 8'hFF, 32'd1);
        send_item(OP_REQUEST,  8'd255, 8'h00, 32'd2);
        send_item(OP_RESPONSE, 8'd255, 8'h00, 32'hFFFF_FFFF);
        send_item(OP_REQUEST,  8'd128, 8'hAA, 32'h0000_0000);
        send_item(OP_REQUEST,  8'd128, 8'h55, 32'd1);
        send_item(OP_REQUEST,  8'd128, 8'hAA, 32'd1);
        send_item(OP_REQUEST,  8'd127, 8'h55, 32'h8000_0000);
        send_item(OP_RESPONSE, 8'd127, 8'hFF, 32'd0);
        send_item(OP_RESPONSE, 8'd127, 8'hFF, 32'd0);
        send_item(OP_REQUEST,  8'd1,   8'h80, 32'd1);
        send_item(OP_REQUEST,  8'd1,   8'h80, 32'd2);
        send_item(OP_REQUEST,  8'd1,   8'h7F, 32'd3);
        send_item(OP_RESPONSE, 8'd2,   8'd0,  32'd0);
        wait_drained();

        // random: well-formed client traffic with broken requests mixed in
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet <= (n % 200) < 40;
            if (n == RANDOM_ITEMS / 2) wait_drained();
            cid  = pick_client();
            pick = $urandom_range(0, 99);
            conn = client_bound[cid] ? client_conn[cid] : CONN_W'($urandom_range(0, 255));
            if (pick < 55) begin
                send_item(OP_REQUEST, cid, conn, client_next[cid]);
            end else if (pick < 75) begin
                send_item(OP_RESPONSE, cid, CONN_W'($urandom_range(0, 255)), $urandom());
            end else if (pick < 87) begin
                send_item(OP_REQUEST, cid, conn ^ CONN_W'($urandom_range(1, 255)),
                          client_next[cid]);
            end else begin
                send_item(OP_REQUEST, cid, conn, $urandom());
            end
        end
        quiet     <= 1'b0;

        // drain and verdict
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && verdicts_due == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/ssc_pkg.sv
sv/ssc_req_if.sv
sv/ssc_rsp_if.sv
sv/ssc_ctrl.sv
sv/ssc_dp.sv
sv/session_sequence_checker.sv
sv/ssc_checker.sv
tb/sv/session_table_checker.sv
tb/sv/session_sequence_checker_tb.sv
